// File: hw/rtl/plist_pkg.sv
// shared types and constants for the positional list engine
package plist_pkg;

  // fixed field widths of the item and result beats
  localparam int unsigned CMD_W = 2;
  localparam int unsigned POS_W = 8;
  localparam int unsigned VAL_W = 64;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned CNT_W = 7;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WALK   = 2'd3;

  // next-value source of one cell
  typedef enum logic [2:0] {
    SEL_HOLD,
    SEL_LEFT,
    SEL_RIGHT,
    SEL_LOAD,
    SEL_HEAD
  } sel_e;

  // control handed to each cell in a cycle
  typedef struct packed {
    sel_e sel;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/positional_list_engine.sv
// top level of the positional list engine: command stage, cell chain and result register
// An item is taken into a command register and then worked on the chain of cells, one cell per
// list entry. Insert and delete shift the chain in a single step, and a new item can be
// accepted in the cycle the previous one finishes, so these run at one item per cycle while
// no result beat is stalled. Find and walk rotate the chain through its head cell once, one
// entry per cycle (a single step when the list is empty); walk gives one result beat per entry
// as it rotates. Every step waits while the result register holds a beat that is stalled.
module positional_list_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [plist_pkg::CMD_W-1:0]   cmd_i,
  input  logic signed [plist_pkg::POS_W-1:0] position_i,
  input  logic [plist_pkg::VAL_W-1:0]   item_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          ok_o,
  output logic [plist_pkg::IDX_W-1:0]   found_index_o,
  output logic [plist_pkg::VAL_W-1:0]   out_value_o,
  output logic                          last_o,
  output logic [plist_pkg::CNT_W-1:0]   count_o,
  output logic                          empty_res_o
);
  import plist_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);

  // command register
  logic                    cmd_valid_q;
  logic [CMD_W-1:0]        cmd_q;
  logic signed [POS_W-1:0] pos_q;
  logic [VAL_W-1:0]        val_q;

  // list state and rotation progress
  logic [CW-1:0]           count_q, count_d;
  logic [IW-1:0]           step_q;
  logic                    found_q;
  logic [IW-1:0]           fidx_q;

  // result register
  logic                    out_valid_q;
  logic                    res_ok_q, res_last_q;
  logic [IDX_W-1:0]        res_idx_q;
  logic [VAL_W-1:0]        res_val_q;
  logic [CW-1:0]           res_cnt_q;

  // chain wiring
  logic [VAL_W-1:0]        cell_val [CAPACITY];
  cell_ctrl_t              cell_ctrl [CAPACITY];

  // step decode
  logic                    out_free;
  logic                    step;
  logic                    done;
  logic                    rotating;
  logic                    last_step;
  logic                    match_now;
  logic signed [POS_W:0]   pos_s, n_s, p_ins, p_del;
  logic                    ins_ok, del_ok;
  logic [POS_W-1:0]        p_ins_u, p_del_u, n_u, n_m1;
  logic                    res_ok, res_last;
  logic [IDX_W-1:0]        res_idx;
  logic [VAL_W-1:0]        res_val;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign step      = cmd_valid_q && out_free;
  assign rotating  = (cmd_q inside {CMD_FIND, CMD_WALK}) && (count_q != '0);
  assign last_step = (CW'(step_q) == count_q - CW'(1));
  assign match_now = (cell_val[0] == val_q);

  // position adjustment and range checks
  always_comb begin
    pos_s   = {pos_q[POS_W-1], pos_q};
    n_s     = signed'((POS_W + 1)'(count_q));
    p_ins   = (pos_s < 0) ? pos_s + n_s + 9'sd1 : pos_s;
    p_del   = (pos_s < 0) ? pos_s + n_s : pos_s;
    ins_ok  = !p_ins[POS_W] && (p_ins <= n_s) && (count_q < CW'(CAPACITY));
    del_ok  = !p_del[POS_W] && (p_del < n_s);
    p_ins_u = p_ins[POS_W-1:0];
    p_del_u = p_del[POS_W-1:0];
    n_u     = POS_W'(count_q);
    n_m1    = n_u - POS_W'(1);
  end

  // per-cell control
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctrl[i].sel = SEL_HOLD;
      if (step) begin
        case (cmd_q)
          CMD_INSERT: begin
            if (ins_ok) begin
              if (POS_W'(i) == p_ins_u) begin
                cell_ctrl[i].sel = SEL_LOAD;
              end else if (POS_W'(i) > p_ins_u && POS_W'(i) <= n_u) begin
                cell_ctrl[i].sel = SEL_LEFT;
              end
            end
          end
          CMD_DELETE: begin
            if (del_ok && POS_W'(i) >= p_del_u && POS_W'(i) < n_m1) begin
              cell_ctrl[i].sel = SEL_RIGHT;
            end
          end
          default: begin
            if (rotating) begin
              if (POS_W'(i) < n_m1) begin
                cell_ctrl[i].sel = SEL_RIGHT;
              end else if (POS_W'(i) == n_m1) begin
                cell_ctrl[i].sel = SEL_HEAD;
              end
            end
          end
        endcase
      end
    end
  end

  // cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_val[g+1];
    end
    plist_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[g]),
      .left_i  (left_w),
      .right_i (right_w),
      .load_i  (val_q),
      .head_i  (cell_val[0]),
      .value_o (cell_val[g])
    );
  end

  // result of the current step and whether the command finishes
  always_comb begin
    count_d  = count_q;
    res_ok   = 1'b0;
    res_idx  = '0;
    res_val  = '0;
    res_last = 1'b1;
    done     = 1'b0;
    case (cmd_q)
      CMD_INSERT: begin
        res_ok = ins_ok;
        done   = step;
        if (step && ins_ok) begin
          count_d = count_q + CW'(1);
        end
      end
      CMD_DELETE: begin
        res_ok = del_ok;
        done   = step;
        if (step && del_ok) begin
          count_d = count_q - CW'(1);
        end
      end
      CMD_FIND: begin
        if (!rotating) begin
          done = step;
        end else begin
          done    = step && last_step;
          res_ok  = found_q || match_now;
          res_idx = found_q ? IDX_W'(fidx_q) : IDX_W'(step_q);
          if (!res_ok) begin
            res_idx = '0;
          end
        end
      end
      default: begin
        if (!rotating) begin
          done = step;
        end else begin
          done     = step && last_step;
          res_ok   = 1'b1;
          res_idx  = IDX_W'(step_q);
          res_val  = cell_val[0];
          res_last = last_step;
        end
      end
    endcase
  end

  assign in_stall_o = cmd_valid_q && !done;

  // command register and list control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      count_q     <= '0;
      step_q      <= '0;
      found_q     <= 1'b0;
      fidx_q      <= '0;
    end else begin
      count_q <= count_d;
      if (in_valid_i && !in_stall_o) begin
        cmd_valid_q <= 1'b1;
      end else if (done) begin
        cmd_valid_q <= 1'b0;
      end
      if (done) begin
        step_q  <= '0;
        found_q <= 1'b0;
        fidx_q  <= '0;
      end else if (step && rotating) begin
        step_q <= step_q + IW'(1);
        if (!found_q && match_now) begin
          found_q <= 1'b1;
          fidx_q  <= step_q;
        end
      end
    end
  end

  // command payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q <= cmd_i;
      pos_q <= position_i;
      val_q <= item_value_i;
    end
  end

  // result beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && (done || (cmd_q == CMD_WALK))) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (step && (done || (cmd_q == CMD_WALK))) begin
      res_ok_q   <= res_ok;
      res_idx_q  <= res_idx;
      res_val_q  <= res_val;
      res_last_q <= res_last;
      res_cnt_q  <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = res_ok_q;
  assign found_index_o = res_idx_q;
  assign out_value_o   = res_val_q;
  assign last_o        = res_last_q;
  assign count_o       = CNT_W'(res_cnt_q);
  assign empty_res_o   = (res_cnt_q == '0);

endmodule

// File: hw/rtl/plist_cell.sv
// one storage cell of the list chain
module plist_cell (
  input  logic                          clk_i,
  input  plist_pkg::cell_ctrl_t         ctrl_i,
  input  logic [plist_pkg::VAL_W-1:0]   left_i,
  input  logic [plist_pkg::VAL_W-1:0]   right_i,
  input  logic [plist_pkg::VAL_W-1:0]   load_i,
  input  logic [plist_pkg::VAL_W-1:0]   head_i,
  output logic [plist_pkg::VAL_W-1:0]   value_o
);
  import plist_pkg::*;

  logic [VAL_W-1:0] value_q;
  logic [VAL_W-1:0] value_d;

  // pick the next value from a neighbour, the load bus or the head
  always_comb begin
    case (ctrl_i.sel)
      SEL_HOLD:  value_d = value_q;
      SEL_LEFT:  value_d = left_i;
      SEL_RIGHT: value_d = right_i;
      SEL_LOAD:  value_d = load_i;
      SEL_HEAD:  value_d = head_i;
      default:   value_d = value_q;
    endcase
  end

  // entry storage, undefined until written
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
